// ----- hdl/pol_pkg.sv -----
package pol_pkg;

    localparam int MAX_EVENTS = 16;
    localparam int LABEL_BITS = 16;
    localparam int IDX_W      = $clog2(MAX_EVENTS);
    localparam int CNT_W      = $clog2(MAX_EVENTS + 1);

    localparam logic [LABEL_BITS-1:0] LABEL_MAX = '1;

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_GT    = 8'h3E;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_BAD_EVT  = 3'd1,
        ST_BAD_PAIR = 3'd2,
        ST_RANGE    = 3'd3,
        ST_MISMATCH = 3'd4,
        ST_FORMAT   = 3'd5
    } status_t;

    typedef struct packed {
        logic                  valid;
        logic [IDX_W-1:0]      addr;
        logic [LABEL_BITS-1:0] data;
    } label_wr_t;

    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] src;
        logic [IDX_W-1:0] dst;
    } pair_t;

    typedef struct packed {
        logic             valid;
        status_t          status;
        logic [CNT_W-1:0] count;
        logic [CNT_W-1:0] labels;
    } line_t;

endpackage

// ----- hdl/pol_parse.sv -----
module pol_parse
    import pol_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  logic [7:0]  char_in,
    input  logic        line_end,
    input  logic [4:0]  event_count,
    output label_wr_t   label_wr,
    output pair_t       pair_set,
    output line_t       line_done
);

    typedef enum logic [1:0] {
        PH_START,
        PH_EVENTS,
        PH_PAIRS
    } phase_t;

    phase_t                phase_reg, phase_next;
    status_t               err_reg, err_next;
    logic [CNT_W-1:0]      decl_reg, decl_next;
    logic [CNT_W-1:0]      nlab_reg, nlab_next;
    logic [LABEL_BITS-1:0] acc_reg, acc_next;
    logic [LABEL_BITS-1:0] pend_reg, pend_next;
    logic                  open_reg, open_next;
    logic                  commit;
    logic                  is_digit;

    function automatic logic [LABEL_BITS-1:0] accum(input logic [LABEL_BITS-1:0] a,
                                                    input logic [7:0] ch);
        logic [LABEL_BITS+3:0] v;
        v = (LABEL_BITS+4)'({a, 3'b000}) + (LABEL_BITS+4)'({a, 1'b0})
            + (LABEL_BITS+4)'(ch[3:0]);
        return (v > (LABEL_BITS+4)'(LABEL_MAX)) ? LABEL_MAX : v[LABEL_BITS-1:0];
    endfunction

    function automatic logic is_space(input logic [7:0] ch);
        return (ch == CH_SPACE) || (ch >= CH_TAB && ch <= CH_CR);
    endfunction

    function automatic logic in_range(input logic [LABEL_BITS-1:0] v,
                                      input logic [CNT_W-1:0] n);
        return (v != '0) && (v <= LABEL_BITS'(n));
    endfunction

    assign is_digit = (char_in >= CH_ZERO) && (char_in <= CH_NINE);

    always_comb
    begin
        phase_next = phase_reg;
        err_next   = err_reg;
        decl_next  = decl_reg;
        nlab_next  = nlab_reg;
        acc_next   = acc_reg;
        pend_next  = pend_reg;
        open_next  = open_reg;
        commit     = 1'b0;
        label_wr   = '0;
        pair_set   = '0;
        line_done  = '0;

        if (accept)
        begin
            // The declared count is taken with the first character of a line.
            if (phase_next == PH_START)
            begin
                phase_next = PH_EVENTS;
                if (32'(event_count) > MAX_EVENTS)
                begin
                    decl_next = CNT_W'(1);
                    err_next  = ST_FORMAT;
                end
                else if (event_count == 5'd0)
                begin
                    decl_next = CNT_W'(1);
                end
                else
                begin
                    decl_next = CNT_W'(event_count);
                end
            end

            if (err_next == ST_OK)
            begin
                if (phase_next == PH_EVENTS)
                begin
                    if (char_in == CH_COMMA || char_in == CH_COLON)
                    begin
                        if (nlab_next >= CNT_W'(MAX_EVENTS))
                        begin
                            err_next = ST_FORMAT;
                        end
                        else
                        begin
                            label_wr.valid = 1'b1;
                            label_wr.addr  = IDX_W'(nlab_next);
                            label_wr.data  = acc_next;
                            nlab_next      = nlab_next + CNT_W'(1);
                        end
                        acc_next = '0;
                        if (char_in == CH_COLON)
                        begin
                            phase_next = PH_PAIRS;
                        end
                    end
                    else if (is_digit)
                    begin
                        acc_next = accum(acc_next, char_in);
                    end
                    else if (!is_space(char_in))
                    begin
                        err_next = ST_BAD_EVT;
                    end
                end
                else
                begin
                    if (char_in == CH_GT)
                    begin
                        pend_next = acc_next;
                        acc_next  = '0;
                        open_next = 1'b1;
                    end
                    else if (char_in == CH_COMMA || char_in == CH_NL)
                    begin
                        commit = 1'b1;
                    end
                    else if (is_digit)
                    begin
                        acc_next  = accum(acc_next, char_in);
                        open_next = 1'b1;
                    end
                    else if (!is_space(char_in))
                    begin
                        err_next = ST_BAD_PAIR;
                    end
                end
            end

            // An unterminated pair is committed at the end of the line.
            if (line_end && err_next == ST_OK && phase_next == PH_PAIRS && open_next)
            begin
                commit = 1'b1;
            end

            if (commit)
            begin
                if (in_range(pend_next, decl_next) && in_range(acc_next, decl_next))
                begin
                    pair_set.valid = 1'b1;
                    pair_set.src   = IDX_W'(pend_next - LABEL_BITS'(1));
                    pair_set.dst   = IDX_W'(acc_next - LABEL_BITS'(1));
                end
                else
                begin
                    err_next = ST_RANGE;
                end
                acc_next  = '0;
                open_next = 1'b0;
            end

            if (line_end)
            begin
                if (err_next == ST_OK && phase_next != PH_PAIRS)
                begin
                    err_next = ST_FORMAT;
                end
                line_done.valid  = 1'b1;
                line_done.status = err_next;
                line_done.count  = decl_next;
                line_done.labels = nlab_next;
                phase_next = PH_START;
                err_next   = ST_OK;
                nlab_next  = '0;
                acc_next   = '0;
                pend_next  = '0;
                open_next  = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_START;
            err_reg   <= ST_OK;
            decl_reg  <= CNT_W'(1);
            nlab_reg  <= '0;
            acc_reg   <= '0;
            pend_reg  <= '0;
            open_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            err_reg   <= err_next;
            decl_reg  <= decl_next;
            nlab_reg  <= nlab_next;
            acc_reg   <= acc_next;
            pend_reg  <= pend_next;
            open_reg  <= open_next;
        end
    end

endmodule

// ----- hdl/pol_closure.sv -----
module pol_closure
    import pol_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  label_wr_t   label_wr,
    input  pair_t       pair_set,
    input  line_t       line_done,
    input  logic        out_stall,
    output logic        busy,
    output logic        out_valid,
    output logic [3:0]  row_index,
    output logic [15:0] event_label,
    output logic [15:0] successors,
    output logic [2:0]  status,
    output logic        last_row
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLOSE,
        S_READ,
        S_LOAD,
        S_HOLD
    } state_t;

    state_t                state_reg, state_next;
    logic [IDX_W-1:0]      cnt_reg, cnt_next;
    logic [CNT_W-1:0]      n_reg, n_next;
    logic [CNT_W-1:0]      nlab_reg, nlab_next;
    logic [MAX_EVENTS-1:0] rel_reg [MAX_EVENTS];
    logic [MAX_EVENTS-1:0] rel_next [MAX_EVENTS];
    logic [MAX_EVENTS-1:0] pivot;
    logic                  at_last;

    logic                  ovalid_reg, ovalid_next;
    logic [IDX_W-1:0]      orow_reg, orow_next;
    logic [LABEL_BITS-1:0] olabel_reg, olabel_next;
    logic [MAX_EVENTS-1:0] osucc_reg, osucc_next;
    status_t               ostat_reg, ostat_next;
    logic                  olast_reg, olast_next;

    logic [LABEL_BITS-1:0] label_mem [MAX_EVENTS];
    logic [LABEL_BITS-1:0] rd_data_reg;

    assign pivot   = rel_reg[cnt_reg];
    assign at_last = (CNT_W'(cnt_reg) == n_reg - CNT_W'(1));

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        n_next      = n_reg;
        nlab_next   = nlab_reg;
        rel_next    = rel_reg;
        ovalid_next = ovalid_reg;
        orow_next   = orow_reg;
        olabel_next = olabel_reg;
        osucc_next  = osucc_reg;
        ostat_next  = ostat_reg;
        olast_next  = olast_reg;

        if (pair_set.valid)
        begin
            rel_next[pair_set.src][pair_set.dst] = 1'b1;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (line_done.valid)
                begin
                    n_next    = line_done.count;
                    nlab_next = line_done.labels;
                    cnt_next  = '0;
                    if (line_done.status != ST_OK)
                    begin
                        ovalid_next = 1'b1;
                        orow_next   = '0;
                        olabel_next = '0;
                        osucc_next  = '0;
                        ostat_next  = line_done.status;
                        olast_next  = 1'b1;
                        state_next  = S_HOLD;
                    end
                    else
                    begin
                        state_next = S_CLOSE;
                    end
                end
            end
            S_CLOSE:
            begin
                // One pivot per cycle: every row that reaches the pivot takes its row.
                for (int i = 0; i < MAX_EVENTS; i++)
                begin
                    if (rel_reg[i][cnt_reg])
                    begin
                        rel_next[i] = rel_reg[i] | pivot;
                    end
                end
                if (at_last)
                begin
                    cnt_next   = '0;
                    state_next = S_READ;
                end
                else
                begin
                    cnt_next = cnt_reg + IDX_W'(1);
                end
            end
            S_READ:
            begin
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                ovalid_next = 1'b1;
                orow_next   = cnt_reg;
                olabel_next = (CNT_W'(cnt_reg) < nlab_reg) ? rd_data_reg : '0;
                osucc_next  = pivot;
                ostat_next  = (nlab_reg != n_reg) ? ST_MISMATCH : ST_OK;
                olast_next  = at_last;
                state_next  = S_HOLD;
            end
            S_HOLD:
            begin
                if (!out_stall)
                begin
                    ovalid_next = 1'b0;
                    if (olast_reg)
                    begin
                        for (int i = 0; i < MAX_EVENTS; i++)
                        begin
                            rel_next[i] = '0;
                        end
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cnt_next   = cnt_reg + IDX_W'(1);
                        state_next = S_READ;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            cnt_reg    <= '0;
            n_reg      <= CNT_W'(1);
            nlab_reg   <= '0;
            for (int i = 0; i < MAX_EVENTS; i++)
            begin
                rel_reg[i] <= '0;
            end
            ovalid_reg <= 1'b0;
            orow_reg   <= '0;
            olabel_reg <= '0;
            osucc_reg  <= '0;
            ostat_reg  <= ST_OK;
            olast_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            n_reg      <= n_next;
            nlab_reg   <= nlab_next;
            rel_reg    <= rel_next;
            ovalid_reg <= ovalid_next;
            orow_reg   <= orow_next;
            olabel_reg <= olabel_next;
            osucc_reg  <= osucc_next;
            ostat_reg  <= ostat_next;
            olast_reg  <= olast_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (label_wr.valid)
        begin
            label_mem[label_wr.addr] <= label_wr.data;
        end
        rd_data_reg <= label_mem[cnt_reg];
    end

    assign busy        = (state_reg != S_IDLE);
    assign out_valid   = ovalid_reg;
    assign row_index   = 4'(orow_reg);
    assign event_label = 16'(olabel_reg);
    assign successors  = 16'(osucc_reg);
    assign status      = ostat_reg;
    assign last_row    = olast_reg;

endmodule

// ----- hdl/partial_order_line_closure.sv -----
// Parses one text line of event labels and precedence pairs, one character per
// transaction, and returns the transitive closure as one row per declared event
// (or a single error row). Characters are taken one per cycle with no stall
// until the transaction that carries line_end. The block then stalls its input:
// the closure takes one pivot row per cycle over the declared events, merging
// it into every row that reaches it in parallel; each row then goes through
// reading the label store, loading the output register and presenting the row,
// where it waits for the taker. An error line gives its one row the cycle after
// line_end. The input is ready again the cycle after the last row is taken.
module partial_order_line_closure
    import pol_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  char_in,
    input  logic        line_end,
    input  logic [4:0]  event_count,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [3:0]  row_index,
    output logic [15:0] event_label,
    output logic [15:0] successors,
    output logic [2:0]  status,
    output logic        last_row
);

    label_wr_t label_wr;
    pair_t     pair_set;
    line_t     line_done;
    logic      busy;
    logic      accept;

    assign in_stall = busy;
    assign accept   = in_valid && !busy;

    pol_parse u_parse (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .char_in     (char_in),
        .line_end    (line_end),
        .event_count (event_count),
        .label_wr    (label_wr),
        .pair_set    (pair_set),
        .line_done   (line_done)
    );

    pol_closure u_closure (
        .clk         (clk),
        .rst_n       (rst_n),
        .label_wr    (label_wr),
        .pair_set    (pair_set),
        .line_done   (line_done),
        .out_stall   (out_stall),
        .busy        (busy),
        .out_valid   (out_valid),
        .row_index   (row_index),
        .event_label (event_label),
        .successors  (successors),
        .status      (status),
        .last_row    (last_row)
    );

endmodule

// ----- dv/tb_partial_order_line_closure.sv -----
`timescale 1ns / 100ps

module tb_partial_order_line_closure;
    import pol_pkg::*;

    localparam logic [7:0] CH_VT = 8'h0B;
    localparam logic [7:0] CH_FF = 8'h0C;

    typedef enum logic [1:0] {
        LINE_START,
        IN_EVENTS,
        IN_PAIRS
    } parse_phase_t;

    typedef struct {
        logic [3:0]  idx;
        logic [15:0] lbl;
        logic [15:0] succ;
        logic [2:0]  st;
        logic        last;
    } closure_row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  char_in;
    logic        line_end;
    logic [4:0]  event_count;
    logic        out_valid;
    logic        out_stall;
    logic [3:0]  row_index;
    logic [15:0] event_label;
    logic [15:0] successors;
    logic [2:0]  status;
    logic        last_row;

    // Predictor state for the line being parsed.
    logic [15:0]           label_mem [MAX_EVENTS];
    logic [MAX_EVENTS-1:0] reach [MAX_EVENTS];
    int unsigned           digits_val;
    int unsigned           source_val;
    int                    n_labels;
    int                    n_declared;
    parse_phase_t          phase;
    status_t               line_err;
    bit                    pair_open;

    closure_row_t rows_due [$];
    closure_row_t want_row;
    logic [7:0]   line_buf [$];
    logic [4:0]   line_cnt;

    int parsed_chars;
    int rows_predicted;
    int row_errors;
    int send_idle_pct;
    int recv_idle_pct;

    partial_order_line_closure u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .char_in     (char_in),
        .line_end    (line_end),
        .event_count (event_count),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .row_index   (row_index),
        .event_label (event_label),
        .successors  (successors),
        .status      (status),
        .last_row    (last_row)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #1_000_000;
        $display("Mismatches found");
        $finish;
    end

    // ---------------------------------------------------------------- predictor

    function automatic bit is_blank(logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_NL || c == CH_VT
            || c == CH_FF || c == CH_CR;
    endfunction

    function automatic bit is_digit(logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic void flag(status_t code);
        if (line_err == ST_OK)
            line_err = code;
    endfunction

    function automatic void add_digit(logic [7:0] c);
        int unsigned v;
        v = digits_val * 10 + (int'(c) - int'(CH_ZERO));
        digits_val = (v > int'(LABEL_MAX)) ? int'(LABEL_MAX) : v;
    endfunction

    function automatic void push_label();
        if (n_labels >= MAX_EVENTS)
            flag(ST_FORMAT);
        else
        begin
            label_mem[n_labels] = digits_val[15:0];
            n_labels++;
        end
        digits_val = 0;
    endfunction

    function automatic void close_pair();
        if (source_val < 1 || source_val > n_declared
            || digits_val < 1 || digits_val > n_declared)
            flag(ST_RANGE);
        else
            reach[source_val - 1][digits_val - 1] = 1'b1;
        digits_val = 0;
        pair_open  = 1'b0;
    endfunction

    function automatic void push_row(int i, logic [15:0] lbl, logic [15:0] succ,
                                     logic [2:0] st, logic last);
        closure_row_t r;
        r.idx  = 4'(i);
        r.lbl  = lbl;
        r.succ = succ;
        r.st   = st;
        r.last = last;
        rows_due.insert(rows_due.size(), r);
        rows_predicted++;
    endfunction

    function automatic void clear_line();
        foreach (reach[i])
            reach[i] = '0;
        digits_val = 0;
        source_val = 0;
        n_labels   = 0;
        phase      = LINE_START;
        line_err   = ST_OK;
        pair_open  = 1'b0;
    endfunction

    // Advances the line parser by one accepted character and, on the line's
    // final character, queues the closure rows (or the single error row).
    function automatic void parse_and_close(logic [7:0] c, logic e, logic [4:0] cnt);
        logic [2:0] row_st;
        if (phase == LINE_START)
        begin
            phase = IN_EVENTS;
            if (cnt > MAX_EVENTS)
            begin
                n_declared = 1;
                flag(ST_FORMAT);
            end
            else
                n_declared = (cnt == 0) ? 1 : int'(cnt);
        end

        if (line_err == ST_OK)
        begin
            parsed_chars++;
            if (phase == IN_EVENTS)
            begin
                if (c == CH_COMMA)
                    push_label();
                else if (c == CH_COLON)
                begin
                    push_label();
                    phase = IN_PAIRS;
                end
                else if (is_digit(c))
                    add_digit(c);
                else if (!is_blank(c))
                    flag(ST_BAD_EVT);
            end
            else
            begin
                if (c == CH_GT)
                begin
                    source_val = digits_val;
                    digits_val = 0;
                    pair_open  = 1'b1;
                end
                else if (c == CH_COMMA || c == CH_NL)
                    close_pair();
                else if (is_digit(c))
                begin
                    add_digit(c);
                    pair_open = 1'b1;
                end
                else if (!is_blank(c))
                    flag(ST_BAD_PAIR);
            end
        end

        if (!e)
            return;

        if (line_err == ST_OK)
        begin
            if (phase != IN_PAIRS)
                flag(ST_FORMAT);
            else if (pair_open)
                close_pair();
        end

        if (line_err != ST_OK)
            push_row(0, '0, '0, line_err, 1'b1);
        else
        begin
            row_st = (n_labels != n_declared) ? ST_MISMATCH : ST_OK;
            // Pivot index outermost, as Warshall requires.
            for (int k = 0; k < n_declared; k++)
                for (int i = 0; i < n_declared; i++)
                    if (reach[i][k])
                        reach[i] |= reach[k];
            for (int i = 0; i < n_declared; i++)
                push_row(i, (i < n_labels) ? label_mem[i] : 16'd0, reach[i], row_st,
                         i == n_declared - 1);
        end
        clear_line();
    endfunction

    // ---------------------------------------------------------------- line building

    function automatic void put_byte(logic [7:0] b);
        line_buf.insert(line_buf.size(), b);
    endfunction

    function automatic void put_text(string s);
        for (int i = 0; i < s.len(); i++)
            line_buf.insert(line_buf.size(), s[i]);
    endfunction

    function automatic void put_num(int unsigned v);
        put_text($sformatf("%0d", v));
    endfunction

    // A newline separates pairs, so it is only used as filler among the labels.
    function automatic void put_blank(bit allow_nl);
        logic [7:0] blanks [6] = '{CH_SPACE, CH_TAB, CH_CR, CH_VT, CH_FF, CH_NL};
        if ($urandom_range(5) == 0)
            line_buf.insert(line_buf.size(), blanks[$urandom_range(allow_nl ? 5 : 4)]);
    endfunction

    function automatic void put_label();
        case ($urandom_range(9))
            0: ;
            1: put_num($urandom_range(65530, 999999));
            2: put_num(int'(LABEL_MAX));
            default: put_num($urandom_range(999));
        endcase
    endfunction

    function automatic void build_random_line();
        int n_ev;
        int n_lab;
        int n_pairs;
        int a;
        int b;
        line_buf.delete();
        case ($urandom_range(19))
            0:
            begin
                n_lab = $urandom_range(1, 8);
                for (int i = 0; i < n_lab; i++)
                    put_byte(8'($urandom_range(255)));
                line_cnt = 5'($urandom_range(31));
            end
            1:
            begin
                n_lab = $urandom_range(MAX_EVENTS + 1, MAX_EVENTS + 3);
                for (int i = 0; i < n_lab; i++)
                begin
                    if (i != 0)
                        put_text(",");
                    put_num($urandom_range(99));
                end
                put_text(":1>2");
                line_cnt = 5'($urandom_range(1, MAX_EVENTS));
            end
            2:
            begin
                put_num($urandom_range(99));
                put_text(",");
                put_num($urandom_range(99));
                line_cnt = 5'($urandom_range(1, MAX_EVENTS));
            end
            3:
            begin
                put_text("1,2:1>");
                if ($urandom_range(1))
                    put_byte(8'($urandom_range(128, 255)));
                else
                    put_byte(8'($urandom_range(8'h3F, 8'h7E)));
                line_cnt = 5'd2;
            end
            4:
            begin
                put_text("3:1>1");
                line_cnt = 5'($urandom_range(MAX_EVENTS + 1, 31));
            end
            default:
            begin
                n_ev  = ($urandom_range(11) == 0) ? MAX_EVENTS : $urandom_range(1, 5);
                n_lab = ($urandom_range(7) == 0) ? $urandom_range(1, MAX_EVENTS) : n_ev;
                line_cnt = (n_ev == 1 && $urandom_range(3) == 0) ? 5'd0 : 5'(n_ev);
                for (int i = 0; i < n_lab; i++)
                begin
                    if (i != 0)
                        put_text(",");
                    put_blank(1'b1);
                    put_label();
                    put_blank(1'b1);
                end
                put_text(":");
                n_pairs = $urandom_range(0, n_ev + 2);
                for (int i = 0; i < n_pairs; i++)
                begin
                    if (i != 0)
                        put_byte(($urandom_range(3) == 0) ? CH_NL : CH_COMMA);
                    a = $urandom_range(1, n_ev);
                    b = ($urandom_range(24) == 0) ? $urandom_range(n_ev + 1, 40)
                                                  : $urandom_range(1, n_ev);
                    // Later pairs sometimes leave out the source and reuse the last one.
                    if (i == 0 || $urandom_range(4) != 0)
                    begin
                        put_blank(1'b0);
                        put_num(a);
                        put_blank(1'b0);
                        put_text(">");
                    end
                    put_blank(1'b0);
                    put_num(b);
                end
                if (n_pairs != 0 && $urandom_range(2) == 0)
                    put_byte(CH_COMMA);
            end
        endcase
    endfunction

    // ---------------------------------------------------------------- driving

    // Called just after a falling edge; returns just after a falling edge, once the character has been accepted.
    task automatic send_char(logic [7:0] c, logic e, logic [4:0] cnt);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid    <= 1'b1;
        char_in     <= c;
        line_end    <= e;
        event_count <= cnt;
        do
            @(posedge clk);
        while (in_stall);
        parse_and_close(c, e, cnt);
        @(negedge clk);
    endtask

    // The declared count only matters on the first character, so the rest carry noise.
    task automatic send_line();
        for (int i = 0; i < line_buf.size(); i++)
            send_char(line_buf[i], i == line_buf.size() - 1,
                      (i == 0) ? line_cnt : 5'($urandom_range(31)));
    endtask

    task automatic send_text(string s, logic [4:0] cnt);
        line_buf.delete();
        put_text(s);
        line_cnt = cnt;
        send_line();
    endtask

    initial
    begin
        forever
        begin
            @(negedge clk);
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // ---------------------------------------------------------------- checking

    function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            row_errors++;
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (rows_due.size() == 0)
            begin
                $error("row %0d arrived with no row pending", row_index);
                row_errors++;
            end
            else
            begin
                want_row = rows_due.pop_front();
                check_field("row_index", want_row.idx, row_index);
                check_field("event_label", want_row.lbl, event_label);
                check_field("successors", want_row.succ, successors);
                check_field("status", want_row.st, status);
                check_field("last_row", want_row.last, last_row);
            end
        end
    end

    // ---------------------------------------------------------------- tests

    // Empty and saturated labels, blanks, a newline separator, a reused source,
    // the pair left open at line end, a short label list and a zero count.
    task automatic test_label_parsing();
        send_idle_pct = 10;
        recv_idle_pct = 85;
        send_text(",99999: 2>3\n1>2,3", 5'd3);
        send_text("5:", 5'd0);
    endtask

    task automatic test_error_lines();
        send_idle_pct = 10;
        recv_idle_pct = 85;
        // A bad character in the labels; everything after it is ignored.
        line_buf.delete();
        put_byte(8'hFF);
        put_text(":1");
        line_cnt = 5'd1;
        send_line();
        send_text("1:a", 5'd1);
        // No source before the first pair reads as position zero.
        send_text("9:3", 5'd1);
        send_text("1", 5'd2);
        send_text("1:", 5'd31);
    endtask

    task automatic test_random_lines(int src_pct, int sink_pct);
        int chars_goal;
        int rows_goal;
        send_idle_pct = src_pct;
        recv_idle_pct = sink_pct;
        chars_goal = parsed_chars + 30;
        rows_goal  = rows_predicted + 6;
        while (parsed_chars < chars_goal || rows_predicted < rows_goal)
        begin
            build_random_line();
            send_line();
        end
    endtask

    initial
    begin
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        char_in     = '0;
        line_end    = 1'b0;
        event_count = 5'd1;
        out_stall   = 1'b0;
        foreach (label_mem[i])
            label_mem[i] = '0;
        n_declared = 1;
        clear_line();

        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        test_label_parsing();
        test_error_lines();
        test_random_lines(10, 85);
        test_random_lines(85, 10);
        test_random_lines(0, 0);

        in_valid <= 1'b0;
        while (rows_due.size() != 0)
            @(posedge clk);
        repeat (3 * MAX_EVENTS + 16) @(posedge clk);

        if (row_errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
